// ----- src/slsp_pkg.sv -----
// Package for the scan line step profile unit: widths, limits and shared types.
// Used by scan_line_step_profile_unit; depends on nothing else.
`default_nettype none

package slsp_pkg;

  localparam int MAX_POINTS = 8192;
  localparam int POS_LIMIT = 8388607;

  // Quotient bits of the step divider and width of its partial remainder.
  localparam int QW = 15;
  localparam int RW = 28;

  localparam logic signed [23:0] START_RESET = 24'sd0;
  localparam logic signed [15:0] STEP_RESET = 16'sd1;
  localparam logic [11:0] RES_RESET = 12'd256;
  localparam logic [10:0] OVER_RESET = 11'd16;

  typedef enum logic [1:0] {
    REG_START_POSITION = 2'd0,
    REG_STEP_SIZE = 2'd1,
    REG_RESOLUTION = 2'd2,
    REG_OVERSCAN = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic neg;
    logic lin;
    logic err;
    logic last;
  } side_t;

endpackage

`default_nettype wire

// ----- src/scan_line_step_profile_unit.sv -----
// Scan line step profile unit: pipelined per-sample position step of a scan line.
// Depends on slsp_pkg.
//
// Usage. Registers are written through the cfg channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high. The user must make writes only
// while no beat is in flight; the block itself does not enforce this. Index 0 is
// the start position, 1 the step size, 2 the resolution and 3 the overscan.
// A beat on the sample channel carries sample_index and is taken when
// sample_valid is high and sample_stall is low. Each sample beat gives exactly
// one result beat (step_delta, last_sample, out_of_range), taken when
// result_valid is high and result_stall is low.
// One beat is taken every cycle while the pipeline is not held; the depth is set
// by the 15-stage restoring divider that forms one quotient bit per stage, after
// three stages of multiplication.
// When the receiver stalls with a result pending, the whole pipeline holds and
// sample_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads start position 0, step size 1,
// resolution 256 and overscan 16.
`default_nettype none

module scan_line_step_profile_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        sample_valid,
  output logic             sample_stall,
  input  wire logic [12:0] sample_index,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic signed [16:0] step_delta,
  output logic             last_sample,
  output logic             out_of_range
);

  localparam int NDIV = slsp_pkg::QW;

  logic signed [23:0] start_position;
  logic signed [15:0] step_size;
  logic [11:0] resolution;
  logic [10:0] overscan;

  logic adv;
  logic [11:0] d2o;

  assign cfg_ready = 1'b1;
  assign adv = !result_valid || !result_stall;
  assign sample_stall = !adv;
  assign d2o = {overscan, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= slsp_pkg::START_RESET;
      step_size <= slsp_pkg::STEP_RESET;
      resolution <= slsp_pkg::RES_RESET;
      overscan <= slsp_pkg::OVER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (slsp_pkg::reg_index_t'(cfg_index))
        slsp_pkg::REG_START_POSITION: start_position <= cfg_data;
        slsp_pkg::REG_STEP_SIZE: step_size <= cfg_data[15:0];
        slsp_pkg::REG_RESOLUTION: resolution <= cfg_data[11:0];
        slsp_pkg::REG_OVERSCAN: overscan <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Stage 1: input register.
  logic s1_valid;
  logic [12:0] s1_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_k <= sample_index;
    end
  end

  // Stage 1 to 2: fold the return path, line length checks, first products.
  logic [12:0] peak_n;
  logic [13:0] twopk;
  logic k_ge;
  logic [12:0] kf_n;
  logic [14:0] len4;
  logic [14:0] kp1;
  logic err0_n;
  logic last_n;
  logic [13:0] w_n;
  logic [21:0] a_n;
  logic [24:0] b_n;
  logic signed [36:0] twoq_n;
  logic [34:0] lim_n;

  always_comb begin
    peak_n = 13'(resolution) + 13'(d2o);
    twopk = {peak_n, 1'b0};
    k_ge = s1_k >= peak_n;
    kf_n = k_ge ? 13'(twopk - 14'd1 - 14'(s1_k)) : s1_k;
    len4 = 15'({resolution, 1'b0}) + 15'({overscan, 2'b00});
    kp1 = 15'(s1_k) + 15'd1;
    err0_n = (kp1 >= len4) || (len4 > 15'(slsp_pkg::MAX_POINTS)) || (overscan == 11'd0);
    last_n = (kp1 + 15'd1) == len4;
    w_n = 14'({resolution, 1'b0}) + 14'(overscan);
    a_n = 22'(overscan) * 22'(overscan);
    b_n = 25'(overscan) * 25'(w_n);
    twoq_n = 37'(start_position) * 37'(signed'({1'b0, d2o}));
    lim_n = 35'(slsp_pkg::POS_LIMIT) * 35'(d2o);
  end

  logic s2_valid;
  logic [12:0] s2_kf;
  logic [12:0] s2_peak;
  logic s2_neg;
  logic s2_err;
  logic s2_last;
  logic [21:0] s2_a;
  logic [24:0] s2_b;
  logic signed [36:0] s2_twoq;
  logic [34:0] s2_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kf <= kf_n;
      s2_peak <= peak_n;
      s2_neg <= k_ge;
      s2_err <= err0_n;
      s2_last <= last_n;
      s2_a <= a_n;
      s2_b <= b_n;
      s2_twoq <= twoq_n;
      s2_lim <= lim_n;
    end
  end

  // Stage 2 to 3: region of the profile and the bound products.
  logic [11:0] m_n;
  logic lin_n;
  logic [12:0] d_n;
  logic signed [38:0] so2_n;
  logic signed [41:0] sb_n;

  always_comb begin
    d_n = s2_peak - s2_kf;
    m_n = 12'd0;
    lin_n = 1'b0;
    if (s2_kf < 13'(overscan)) begin
      m_n = {s2_kf[10:0], 1'b1};
    end else if (s2_kf < 13'(overscan) + 13'(resolution)) begin
      lin_n = 1'b1;
    end else begin
      m_n = {d_n[10:0], 1'b0} - 12'd1;
    end
    so2_n = 39'(step_size) * 39'(signed'({1'b0, s2_a}));
    sb_n = 42'(step_size) * 42'(signed'({1'b0, s2_b}));
  end

  logic s3_valid;
  logic [11:0] s3_m;
  slsp_pkg::side_t s3_side;
  logic signed [38:0] s3_so2;
  logic signed [41:0] s3_sb;
  logic signed [36:0] s3_twoq;
  logic [34:0] s3_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_m <= m_n;
      s3_side <= '{neg: s2_neg, lin: lin_n, err: s2_err, last: s2_last};
      s3_so2 <= so2_n;
      s3_sb <= sb_n;
      s3_twoq <= s2_twoq;
      s3_lim <= s2_lim;
    end
  end

  // Stage 3 to divider: numerator magnitude and the scaled start and peak.
  logic [15:0] sabs;
  logic [slsp_pkg::RW-1:0] prod_n;
  logic signed [42:0] q0_n;
  logic signed [42:0] qpk_n;

  always_comb begin
    sabs = step_size[15] ? 16'(-step_size) : 16'(step_size);
    prod_n = slsp_pkg::RW'(sabs) * slsp_pkg::RW'(s3_m);
    q0_n = 43'(s3_twoq) - 43'(s3_so2);
    qpk_n = 43'(s3_twoq) + 43'(s3_sb);
  end

  logic dv_valid [0:NDIV];
  logic [slsp_pkg::RW-1:0] dv_rem [0:NDIV];
  logic [slsp_pkg::QW-1:0] dv_quo [0:NDIV];
  slsp_pkg::side_t dv_side [0:NDIV];
  logic signed [42:0] dv_q0;
  logic signed [42:0] dv_qpk;
  logic [34:0] dv_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= prod_n;
      dv_quo[0] <= '0;
      dv_side[0] <= s3_side;
      dv_q0 <= q0_n;
      dv_qpk <= qpk_n;
      dv_lim <= s3_lim;
    end
  end

  logic signed [42:0] lim43;
  logic bound_err;

  always_comb begin
    lim43 = signed'(43'(dv_lim));
    bound_err = (dv_q0 <= -lim43) || (dv_q0 >= lim43) ||
                (dv_qpk <= -lim43) || (dv_qpk >= lim43);
  end

  // Restoring divider by twice the overscan, one quotient bit per stage.
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [slsp_pkg::RW-1:0] trial;
    logic take;
    slsp_pkg::side_t side_next;

    always_comb begin
      trial = slsp_pkg::RW'(d2o) << (NDIV - 1 - j);
      take = dv_rem[j] >= trial;
      side_next = dv_side[j];
      if (j == 0) begin
        side_next.err = dv_side[j].err || bound_err;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j+1] <= take ? dv_rem[j] - trial : dv_rem[j];
        dv_quo[j+1] <= dv_quo[j] | (slsp_pkg::QW'(take) << (NDIV - 1 - j));
        dv_side[j+1] <= side_next;
      end
    end
  end

  // Output stage: sign of the step and of the return path.
  logic signed [16:0] mag;
  logic signed [16:0] val;
  logic signed [16:0] delta_n;

  always_comb begin
    mag = signed'(17'(dv_quo[NDIV]));
    if (dv_side[NDIV].lin) begin
      val = 17'(step_size);
    end else begin
      val = step_size[15] ? -mag : mag;
    end
    delta_n = dv_side[NDIV].neg ? -val : val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_valid[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step_delta <= dv_side[NDIV].err ? 17'sd0 : delta_n;
      last_sample <= dv_side[NDIV].last && !dv_side[NDIV].err;
      out_of_range <= dv_side[NDIV].err;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_of_range |-> step_delta == 17'sd0 && !last_sample)
    else $error("error result carries a non-zero step or last flag");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    dv_valid[NDIV] && !dv_side[NDIV].err |-> dv_rem[NDIV] < slsp_pkg::RW'(d2o))
    else $error("divider remainder not below the divisor");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1_k) && $stable(dv_quo[NDIV]))
    else $error("pipeline moved while held");

  a_reset_cfg: assert property (@(posedge clk)
    $past(rst) && !$past(cfg_valid) |-> overscan == slsp_pkg::OVER_RESET &&
      resolution == slsp_pkg::RES_RESET && step_size == slsp_pkg::STEP_RESET)
    else $error("registers not at reset values after reset");

endmodule

`default_nettype wire
